// ===== hdl/kpd_pkg.sv =====
// Package for the key matrix debouncer: sizes, codes, item and row-state types.
// Used by the top level and kpd_row_update; depends on nothing.
package kpd_pkg;

  localparam int ROWS     = 16;
  localparam int RowW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KeyW     = 8;
  localparam int RowIdxW  = 4;
  localparam int HoldN    = 3;
  localparam int HoldRowW = 4;
  localparam int PaddrW   = 5;
  localparam int PdataW   = 32;

  // Command codes carried in the command field.
  typedef enum logic [2:0] {
    CMD_SCAN   = 3'd0,
    CMD_PRESS  = 3'd1,
    CMD_REPEAT = 3'd2,
    CMD_SHORT  = 3'd3,
    CMD_LONG   = 3'd4
  } cmd_e;

  // Register indexes on the configuration port (word address).
  typedef enum logic [2:0] {
    REG_IGNORE_MASK  = 3'd0,
    REG_REPEAT_MASK  = 3'd1,
    REG_REPEAT_START = 3'd2,
    REG_REPEAT_NEXT  = 3'd3,
    REG_HOLD_ROWS    = 3'd4,
    REG_HOLD_MASKS   = 3'd5
  } reg_e;

  localparam logic [7:0]  RepeatStartRst = 8'd50;
  localparam logic [7:0]  RepeatNextRst  = 8'd20;
  localparam logic [11:0] HoldRowsRst    = 12'd3013;

  typedef struct packed {
    logic [2:0]      command;
    logic [KeyW-1:0] pins;
    logic [KeyW-1:0] query_mask;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0]    keys;
    logic [RowIdxW-1:0] row_index;
  } out_item_t;

  typedef struct packed {
    logic [KeyW-1:0]           ignore_mask;
    logic [KeyW-1:0]           rpt_keys;
    logic [7:0]                rpt_first;
    logic [7:0]                rpt_gap;
    logic [HoldN*HoldRowW-1:0] hold_rows;
    logic [HoldN*KeyW-1:0]     hold_masks;
  } cfg_t;

  // Everything one row keeps; one memory word.
  typedef struct packed {
    logic [KeyW-1:0] count_low;
    logic [KeyW-1:0] count_high;
    logic [KeyW-1:0] debounced;
    logic [KeyW-1:0] press_latch;
    logic [KeyW-1:0] repeat_latch;
    logic [7:0]      repeat_counter;
  } row_t;

  localparam int RowStateW = $bits(row_t);

endpackage

// ===== hdl/keypad_matrix_debounce_repeat.sv =====
// Top level of the scanned key matrix debouncer with press latch and auto repeat.
// Depends on kpd_pkg, kpd_ram and kpd_row_update.
//
// Each row keeps its debounce counters, debounced keys, press and repeat latches
// and repeat counter in one word of a 16-entry RAM. An item is accepted into
// stage 1, which also issues the read of the current row; when stage 1
// advances, the new word is computed from the row word and written back,
// and the result moves into the output register. The block takes one item
// every cycle while the output register is not stalled. When consecutive
// items touch the same row, the word written on the edge of the read is taken
// from a bypass register instead of the RAM. Per-row valid bits, cleared by
// reset, make unwritten rows read as all zero, so there is no clearing pass
// after reset. A scan advances the row pointer; queries act on the row it names.
// Configuration is by an APB-style port with word registers at 4*index.
module keypad_matrix_debounce_repeat (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  kpd_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output kpd_pkg::out_item_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kpd_pkg::PaddrW-1:0]      paddr,
  input  logic [kpd_pkg::PdataW-1:0]      pwdata,
  output logic [kpd_pkg::PdataW-1:0]      prdata,
  output logic                            pready
);
  import kpd_pkg::*;

  // Configuration registers.
  cfg_t       cfg_q;
  logic       cfg_wr;
  reg_e       cfg_idx;

  // Row pointer and stage 1 (row read in flight).
  logic [RowW-1:0] row_ptr_q, row_ptr_d;
  logic            s1_valid_q;
  in_item_t        s1_item_q;
  logic [RowW-1:0] s1_row_q;

  // Bypass of the last written row word.
  logic            byp_valid_q;
  logic [RowW-1:0] byp_row_q;
  row_t            byp_data_q;

  // Rows written since reset.
  logic [ROWS-1:0] row_vld_q;

  // Output register.
  logic       out_valid_q;
  out_item_t  out_data_q;

  logic            in_fire;
  logic            s1_adv;
  row_t            ram_rdata;
  row_t            row_old;
  row_t            row_new;
  logic [KeyW-1:0] keys;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_e'(paddr[PaddrW-1:2]);

  // Hold configuration registers; write on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ignore_mask <= '0;
      cfg_q.rpt_keys    <= '0;
      cfg_q.rpt_first   <= RepeatStartRst;
      cfg_q.rpt_gap     <= RepeatNextRst;
      cfg_q.hold_rows   <= HoldRowsRst;
      cfg_q.hold_masks  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IGNORE_MASK:  cfg_q.ignore_mask <= pwdata[KeyW-1:0];
        REG_REPEAT_MASK:  cfg_q.rpt_keys    <= pwdata[KeyW-1:0];
        REG_REPEAT_START: cfg_q.rpt_first   <= pwdata[7:0];
        REG_REPEAT_NEXT:  cfg_q.rpt_gap     <= pwdata[7:0];
        REG_HOLD_ROWS:    cfg_q.hold_rows   <= pwdata[HoldN*HoldRowW-1:0];
        REG_HOLD_MASKS:   cfg_q.hold_masks  <= pwdata[HoldN*KeyW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    case (cfg_idx)
      REG_IGNORE_MASK:  prdata = PdataW'(cfg_q.ignore_mask);
      REG_REPEAT_MASK:  prdata = PdataW'(cfg_q.rpt_keys);
      REG_REPEAT_START: prdata = PdataW'(cfg_q.rpt_first);
      REG_REPEAT_NEXT:  prdata = PdataW'(cfg_q.rpt_gap);
      REG_HOLD_ROWS:    prdata = PdataW'(cfg_q.hold_rows);
      REG_HOLD_MASKS:   prdata = PdataW'(cfg_q.hold_masks);
      default:          prdata = '0;
    endcase
  end

  // Stage 1 advances when the output register is free or being emptied.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Advance the row pointer on every accepted scan, wrapping after the last row.
  always_comb begin
    row_ptr_d = row_ptr_q;
    if (in_fire && cmd_e'(in_data_i.command) == CMD_SCAN) begin
      row_ptr_d = (int'(row_ptr_q) >= ROWS - 1) ? '0 : row_ptr_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ptr_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_ptr_q <= row_ptr_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
      s1_row_q  <= row_ptr_q;
    end
  end

  kpd_ram #(
    .Width (RowStateW),
    .Depth (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_row_q),
    .wdata_i (row_new),
    .re_i    (in_fire),
    .raddr_i (row_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Pick the row word: fresh write first, then the RAM, zero for unwritten rows.
  always_comb begin
    if (byp_valid_q && byp_row_q == s1_row_q) begin
      row_old = byp_data_q;
    end else if (row_vld_q[s1_row_q]) begin
      row_old = ram_rdata;
    end else begin
      row_old = '0;
    end
  end

  kpd_row_update u_update (
    .cfg_i  (cfg_q),
    .item_i (s1_item_q),
    .row_i  (s1_row_q),
    .old_i  (row_old),
    .new_o  (row_new),
    .keys_o (keys)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        byp_valid_q          <= 1'b1;
        row_vld_q[s1_row_q]  <= 1'b1;
        out_valid_q          <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      byp_row_q            <= s1_row_q;
      byp_data_q           <= row_new;
      out_data_q.keys      <= keys;
      out_data_q.row_index <= RowIdxW'(s1_row_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The row pointer moves only on an accepted item.
  a_ptr_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(row_ptr_q))
    else $error("row pointer moved without an accepted item");

  // A blocked stage 1 keeps its item and row.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_item_q) && $stable(s1_row_q))
    else $error("stage 1 item lost while stalled");

  // A write-back always lands a result in the output register.
  a_wb_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q && byp_valid_q && row_vld_q[byp_row_q])
    else $error("write-back without a result");

endmodule

// ===== hdl/kpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module kpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/kpd_row_update.sv =====
// Next row state and answer for one item: debounce, latch, repeat, query clear.
// Depends on kpd_pkg.
module kpd_row_update (
  input  kpd_pkg::cfg_t                cfg_i,
  input  kpd_pkg::in_item_t            item_i,
  input  logic [kpd_pkg::RowW-1:0]     row_i,
  input  kpd_pkg::row_t                old_i,
  output kpd_pkg::row_t                new_o,
  output logic [kpd_pkg::KeyW-1:0]     keys_o
);
  import kpd_pkg::*;

  logic [KeyW-1:0] hold_keep;
  logic [KeyW-1:0] change;
  logic [KeyW-1:0] flip;
  logic [KeyW-1:0] cl_new;
  logic [KeyW-1:0] ch_new;
  logic [KeyW-1:0] db_new;
  logic [7:0]      rc_base;
  logic [7:0]      rc_dec;
  logic [KeyW-1:0] press_m;
  logic [KeyW-1:0] rep_m;

  // Keys of this row that a press, short or long read leaves latched.
  always_comb begin
    logic [HoldRowW-1:0] hrow;
    hold_keep = '0;
    for (int i = 0; i < HoldN; i++) begin
      hrow = cfg_i.hold_rows[i*HoldRowW +: HoldRowW];
      if (int'(hrow) < ROWS && hrow == HoldRowW'(row_i)) begin
        hold_keep = hold_keep | cfg_i.hold_masks[i*KeyW +: KeyW];
      end
    end
  end

  // Vertical counter scan path.
  always_comb begin
    change  = old_i.debounced ^ ~(cfg_i.ignore_mask | item_i.pins);
    cl_new  = ~(old_i.count_low & change);
    ch_new  = cl_new ^ (old_i.count_high & change);
    flip    = change & cl_new & ch_new;
    db_new  = old_i.debounced ^ flip;
    rc_base = ((db_new & cfg_i.rpt_keys) == '0) ? cfg_i.rpt_first
                                                : old_i.repeat_counter;
    rc_dec  = rc_base - 8'd1;
  end

  always_comb begin
    new_o   = old_i;
    keys_o  = '0;
    press_m = '0;
    rep_m   = '0;
    case (cmd_e'(item_i.command))
      CMD_SCAN: begin
        new_o.count_low   = cl_new;
        new_o.count_high  = ch_new;
        new_o.debounced   = db_new;
        new_o.press_latch = old_i.press_latch | (db_new & flip);
        if (rc_dec == 8'd0) begin
          new_o.repeat_counter = cfg_i.rpt_gap;
          new_o.repeat_latch   = old_i.repeat_latch | (db_new & cfg_i.rpt_keys);
        end else begin
          new_o.repeat_counter = rc_dec;
        end
        keys_o = db_new;
      end
      CMD_PRESS: begin
        press_m           = item_i.query_mask & old_i.press_latch;
        new_o.press_latch = old_i.press_latch & ~(press_m & ~hold_keep);
        keys_o            = press_m;
      end
      CMD_REPEAT: begin
        rep_m              = item_i.query_mask & old_i.repeat_latch;
        new_o.repeat_latch = old_i.repeat_latch & ~rep_m;
        keys_o             = rep_m;
      end
      CMD_SHORT: begin
        press_m           = item_i.query_mask & ~old_i.debounced & old_i.press_latch;
        new_o.press_latch = old_i.press_latch & ~(press_m & ~hold_keep);
        keys_o            = press_m;
      end
      CMD_LONG: begin
        rep_m              = item_i.query_mask & old_i.repeat_latch;
        new_o.repeat_latch = old_i.repeat_latch & ~rep_m;
        press_m            = rep_m & old_i.press_latch;
        new_o.press_latch  = old_i.press_latch & ~(press_m & ~hold_keep);
        keys_o             = press_m;
      end
      default: begin
        keys_o = '0;
      end
    endcase
  end

endmodule
